FILE: rtl/kvtt_pkg.sv
// Shared types and constants of the key/value text tokenizer.
`default_nettype none
package kvtt_pkg;

    localparam logic [2:0] KIND_KEY  = 3'd0;
    localparam logic [2:0] KIND_VAL  = 3'd1;
    localparam logic [2:0] KIND_HEX  = 3'd2;
    localparam logic [2:0] KIND_PAIR = 3'd3;
    localparam logic [2:0] KIND_DONE = 3'd4;
    localparam logic [2:0] KIND_ERR  = 3'd5;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_H      = 8'h68;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_X      = 8'h78;

    localparam logic [2:0][7:0] HEX_PREFIX = {CH_X, CH_E, CH_H};

    typedef struct packed {
        logic [1:0] held;
        logic       has_main;
        logic [7:0] main_byte;
        logic [2:0] main_kind;
        logic       add_done;
    } t_cmd;

endpackage
`default_nettype wire

FILE: rtl/kvtt_front.sv
// Front end: parses each text byte and turns it into at most one result command.
`default_nettype none
module kvtt_front (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire  [7:0]       i_byte,
    input  wire              i_full,
    output logic             o_ready,
    output logic             o_push,
    output kvtt_pkg::t_cmd   o_cmd
);
    import kvtt_pkg::*;

    typedef enum logic [3:0] {
        ST_WS, ST_KEY, ST_AFTER_KEY, ST_VAL_START, ST_BARE, ST_DQ, ST_DQ_ESC,
        ST_SQ, ST_SQ_ESC, ST_HEX, ST_PEND_H, ST_PEND_HE, ST_PEND_HEX
    } t_state;

    t_state     r_state, n_state;
    logic [3:0] r_hi, n_hi;
    logic       r_pend, n_pend;
    logic       r_disc, n_disc;
    t_cmd       cmd;
    logic       accept;
    logic       is_ws;
    logic       is_nul;
    logic       is_hex;
    logic [3:0] hex_d;
    logic [7:0] c;

    assign c       = i_byte;
    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign is_nul  = (c == CH_NUL);
    assign is_ws   = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

    always_comb begin
        is_hex = 1'b1;
        hex_d  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            hex_d = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            hex_d = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            hex_d = 4'(c - 8'h57);
        end else begin
            is_hex = 1'b0;
        end
    end

    always_comb begin
        n_state = r_state;
        n_hi    = r_hi;
        n_pend  = r_pend;
        n_disc  = r_disc;
        cmd     = '0;
        if (r_disc) begin
            if (is_nul) begin
                n_state = ST_WS;
                n_hi    = 4'd0;
                n_pend  = 1'b0;
                n_disc  = 1'b0;
            end
        end else begin
            case (r_state)
                ST_KEY: begin
                    if (is_nul || (!is_ws && c != CH_EQ && c[7])) begin
                        cmd.has_main  = 1'b1;
                        cmd.main_kind = KIND_ERR;
                        n_state = ST_WS;
                        n_disc  = !is_nul;
                    end else if (c == CH_EQ) begin
                        n_state = ST_VAL_START;
                    end else if (is_ws) begin
                        n_state = ST_AFTER_KEY;
                    end else begin
                        cmd.has_main  = 1'b1;
                        cmd.main_byte = c;
                        cmd.main_kind = KIND_KEY;
                    end
                end
                ST_AFTER_KEY: begin
                    if (c == CH_EQ) begin
                        n_state = ST_VAL_START;
                    end else if (is_nul || !is_ws) begin
                        cmd.has_main  = 1'b1;
                        cmd.main_kind = KIND_ERR;
                        n_state = ST_WS;
                        n_disc  = !is_nul;
                    end
                end
                ST_VAL_START: begin
                    if (is_nul) begin
                        cmd.has_main  = 1'b1;
                        cmd.main_kind = KIND_ERR;
                        n_state = ST_WS;
                    end else if (c == CH_H) begin
                        n_state = ST_PEND_H;
                    end else if (c == CH_SQUOTE) begin
                        n_state = ST_SQ;
                    end else if (c == CH_DQUOTE) begin
                        n_state = ST_DQ;
                    end else if (!is_ws) begin
                        cmd.has_main  = 1'b1;
                        cmd.main_byte = c;
                        cmd.main_kind = KIND_VAL;
                        n_state = ST_BARE;
                    end
                end
                ST_BARE, ST_PEND_H, ST_PEND_HE, ST_PEND_HEX: begin
                    if (r_state == ST_PEND_H && c == CH_E) begin
                        n_state = ST_PEND_HE;
                    end else if (r_state == ST_PEND_HE && c == CH_X) begin
                        n_state = ST_PEND_HEX;
                    end else if (r_state == ST_PEND_HEX && c == CH_COLON) begin
                        n_state = ST_HEX;
                        n_hi    = 4'd0;
                        n_pend  = 1'b0;
                    end else begin
                        case (r_state)
                            ST_PEND_H:   cmd.held = 2'd1;
                            ST_PEND_HE:  cmd.held = 2'd2;
                            ST_PEND_HEX: cmd.held = 2'd3;
                            default:     cmd.held = 2'd0;
                        endcase
                        n_state       = ST_BARE;
                        cmd.has_main  = 1'b1;
                        if (is_nul || is_ws) begin
                            cmd.main_kind = KIND_PAIR;
                            cmd.add_done  = is_nul;
                            n_state       = ST_WS;
                            if (is_nul) begin
                                n_hi   = 4'd0;
                                n_pend = 1'b0;
                            end
                        end else begin
                            cmd.main_byte = c;
                            cmd.main_kind = KIND_VAL;
                        end
                    end
                end
                ST_DQ, ST_SQ: begin
                    if (is_nul) begin
                        cmd.has_main  = 1'b1;
                        cmd.main_kind = KIND_ERR;
                        n_state = ST_WS;
                    end else if ((r_state == ST_DQ && c == CH_DQUOTE) ||
                                 (r_state == ST_SQ && c == CH_SQUOTE)) begin
                        cmd.has_main  = 1'b1;
                        cmd.main_kind = KIND_PAIR;
                        n_state = ST_WS;
                    end else if (c == CH_BSLASH) begin
                        n_state = (r_state == ST_DQ) ? ST_DQ_ESC : ST_SQ_ESC;
                    end else begin
                        cmd.has_main  = 1'b1;
                        cmd.main_byte = c;
                        cmd.main_kind = KIND_VAL;
                    end
                end
                ST_DQ_ESC, ST_SQ_ESC: begin
                    cmd.has_main = 1'b1;
                    if (is_nul) begin
                        cmd.main_kind = KIND_ERR;
                        n_state = ST_WS;
                    end else begin
                        cmd.main_byte = c;
                        cmd.main_kind = KIND_VAL;
                        n_state = (r_state == ST_DQ_ESC) ? ST_DQ : ST_SQ;
                    end
                end
                ST_HEX: begin
                    if (is_hex) begin
                        if (r_pend) begin
                            cmd.has_main  = 1'b1;
                            cmd.main_byte = {r_hi, hex_d};
                            cmd.main_kind = KIND_HEX;
                            n_pend = 1'b0;
                            n_hi   = 4'd0;
                        end else begin
                            n_hi   = hex_d;
                            n_pend = 1'b1;
                        end
                    end else begin
                        cmd.has_main = 1'b1;
                        n_state      = ST_WS;
                        if ((is_nul || is_ws) && !r_pend) begin
                            cmd.main_kind = KIND_PAIR;
                            cmd.add_done  = is_nul;
                        end else begin
                            cmd.main_kind = KIND_ERR;
                            n_hi   = 4'd0;
                            n_pend = 1'b0;
                            n_disc = !is_nul;
                        end
                    end
                end
                default: begin
                    if (is_nul) begin
                        cmd.has_main  = 1'b1;
                        cmd.main_kind = KIND_DONE;
                        n_state = ST_WS;
                        n_hi    = 4'd0;
                        n_pend  = 1'b0;
                    end else if (c == CH_EQ || (!is_ws && c[7])) begin
                        cmd.has_main  = 1'b1;
                        cmd.main_kind = KIND_ERR;
                        n_state = ST_WS;
                        n_disc  = 1'b1;
                    end else if (!is_ws) begin
                        cmd.has_main  = 1'b1;
                        cmd.main_byte = c;
                        cmd.main_kind = KIND_KEY;
                        n_state = ST_KEY;
                    end
                end
            endcase
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && (cmd.has_main || (cmd.held != 2'd0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_WS;
            r_hi    <= 4'd0;
            r_pend  <= 1'b0;
            r_disc  <= 1'b0;
        end else if (accept) begin
            r_state <= n_state;
            r_hi    <= n_hi;
            r_pend  <= n_pend;
            r_disc  <= n_disc;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/kvtt_queue.sv
// Short command queue between the parser front end and the result back end.
`default_nettype none
module kvtt_queue #(
    parameter int DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  kvtt_pkg::t_cmd   i_cmd,
    input  wire              i_pop,
    output logic             o_full,
    output logic             o_empty,
    output kvtt_pkg::t_cmd   o_cmd
);
    import kvtt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: rtl/kvtt_back.sv
// Back end: expands each command into tagged result transactions.
`default_nettype none
module kvtt_back (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_empty,
    input  kvtt_pkg::t_cmd   i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  wire              i_ready,
    output logic [7:0]       o_byte,
    output logic [2:0]       o_kind,
    output logic             o_last
);
    import kvtt_pkg::*;

    logic [2:0] r_step;
    logic       r_valid;
    logic [7:0] r_byte;
    logic [2:0] r_kind;
    logic       r_last;
    logic       load;
    logic [2:0] total;
    logic       item_last;
    logic [7:0] item_byte;
    logic [2:0] item_kind;

    assign total = 3'(i_cmd.held) + 3'(i_cmd.has_main) + 3'(i_cmd.add_done);
    assign item_last = (r_step == total - 3'd1);
    assign load  = !r_valid || i_ready;
    assign o_pop = load && !i_empty && item_last;

    always_comb begin
        if (r_step < 3'(i_cmd.held)) begin
            item_byte = HEX_PREFIX[r_step[1:0]];
            item_kind = KIND_VAL;
        end else if (r_step == 3'(i_cmd.held) && i_cmd.has_main) begin
            item_byte = i_cmd.main_byte;
            item_kind = i_cmd.main_kind;
        end else begin
            item_byte = 8'd0;
            item_kind = KIND_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 3'd0;
        end else if (load) begin
            r_valid <= !i_empty;
            if (!i_empty) begin
                r_step <= item_last ? 3'd0 : r_step + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_byte <= item_byte;
            r_kind <= item_kind;
            r_last <= item_last;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_kind  = r_kind;
    assign o_last  = r_last;

endmodule
`default_nettype wire

FILE: rtl/key_value_text_tokenizer.sv
// Top level of the key/value text tokenizer: front end, queue and back end.
// Usage:
// The slave channel takes one text byte per transaction in s_axis_tdata; a zero
// byte ends the text. The master channel gives one tagged result per transaction:
// m_axis_tdata carries the key, value or decoded hex byte, m_axis_tuser the kind
// (key, value, hex, pair end, done, error) and m_axis_tlast marks the final result
// that one input byte causes. The front end parses one byte per cycle while the
// queue is not full and pushes its commands into a queue of FIFO_DEPTH entries;
// the back end expands each command at one result per cycle while the receiver is
// ready. A byte's first result passes through the queue and the output register.
// Bytes with no or one result sustain one byte per cycle while the output keeps
// up; a byte with n results holds the output until all n are given, and the queue
// absorbs short bursts. The slave tready drops only while the queue is full. When
// the receiver stalls, the output register holds its transaction and the queue
// fills; then input stalls too. Reset clears the parser state, the queue and the
// output valid, and the block is ready for a new text at once.
`default_nettype none
module key_value_text_tokenizer #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  wire  [7:0] i_s_axis_tdata,   // [7:0] in_byte
    output logic       o_m_axis_tvalid,
    input  wire        i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] o_m_axis_tuser,   // [2:0] kind
    output logic       o_m_axis_tlast
);
    import kvtt_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic push, pop, full, empty;

    kvtt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_byte  (i_s_axis_tdata),
        .i_full  (full),
        .o_ready (o_s_axis_tready),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    kvtt_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    kvtt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (queue_cmd),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_byte  (o_m_axis_tdata),
        .o_kind  (o_m_axis_tuser),
        .o_last  (o_m_axis_tlast)
    );

endmodule
`default_nettype wire
